[design/des_known_plaintext_key_check_assert.svh]
// Assertion macros for the DES key checker.
`ifndef DES_KNOWN_PLAINTEXT_KEY_CHECK_ASSERT_SVH
`define DES_KNOWN_PLAINTEXT_KEY_CHECK_ASSERT_SVH
// Same-cycle implication.
`define KC_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define KC_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[design/deskc_pkg.sv]
// DES tables and permutation helpers for the key checker.
`timescale 1ns / 1ps
package deskc_pkg;

    localparam int NumRounds = 16;

    localparam byte unsigned IP_TAB [64] = '{
        58,50,42,34,26,18,10,2,60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6,64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5,63,55,47,39,31,23,15,7};

    localparam byte unsigned FP_TAB [64] = '{
        40,8,48,16,56,24,64,32,39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30,37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28,35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26,33,1,41,9,49,17,57,25};

    localparam byte unsigned E_TAB [48] = '{
        32,1,2,3,4,5,4,5,6,7,8,9,8,9,10,11,12,13,12,13,14,15,16,17,
        16,17,18,19,20,21,20,21,22,23,24,25,24,25,26,27,28,29,28,29,30,31,32,1};

    localparam byte unsigned P_TAB [32] = '{
        16,7,20,21,29,12,28,17,1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,19,13,30,6,22,11,4,25};

    localparam byte unsigned PC1_TAB [56] = '{
        57,49,41,33,25,17,9,1,58,50,42,34,26,18,
        10,2,59,51,43,35,27,19,11,3,60,52,44,36,
        63,55,47,39,31,23,15,7,62,54,46,38,30,22,
        14,6,61,53,45,37,29,21,13,5,28,20,12,4};

    localparam byte unsigned PC2_TAB [48] = '{
        14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
        41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};

    localparam byte unsigned ROT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] SBOX [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    // Initial permutation (pure wiring).
    function automatic logic [63:0] ip_perm(input logic [63:0] x);
        logic [63:0] o;
        for (int j = 0; j < 64; j++) o[63-j] = x[64-int'(IP_TAB[j])];
        return o;
    endfunction

    function automatic logic [63:0] fp_perm(input logic [63:0] x);
        logic [63:0] o;
        for (int j = 0; j < 64; j++) o[63-j] = x[64-int'(FP_TAB[j])];
        return o;
    endfunction

    // Insert parity gaps, then PC-1.
    function automatic logic [55:0] pc1_perm(input logic [55:0] k);
        logic [63:0] k64;
        logic [55:0] o;
        k64 = '0;
        for (int i = 0; i < 56; i++) k64[8*(i/7) + (i%7) + 1] = k[i];
        for (int j = 0; j < 56; j++) o[55-j] = k64[64-int'(PC1_TAB[j])];
        return o;
    endfunction

    function automatic logic [47:0] pc2_perm(input logic [55:0] cd);
        logic [47:0] o;
        for (int j = 0; j < 48; j++) o[47-j] = cd[56-int'(PC2_TAB[j])];
        return o;
    endfunction

    function automatic logic [27:0] rot28(input logic [27:0] v, input logic two);
        return two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    endfunction

    function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] x;
        logic [5:0]  b;
        logic [31:0] s_out;
        logic [31:0] o;
        for (int j = 0; j < 48; j++) x[47-j] = r[32-int'(E_TAB[j])];
        x = x ^ k;
        for (int s = 0; s < 8; s++) begin
            b = x[47-6*s -: 6];
            s_out[31-4*s -: 4] = SBOX[s][{b[5], b[0], b[4:1]}];
        end
        for (int j = 0; j < 32; j++) o[31-j] = s_out[32-int'(P_TAB[j])];
        return o;
    endfunction

endpackage

[design/des_known_plaintext_key_check.sv]
// Top level: fully pipelined DES known-plaintext key checker.
//
// Usage:
//   Input channel s_valid/s_ready/s_key carries one 56-bit candidate key per
//   beat (parity bits removed). Output channel m_valid/m_ready carries one
//   beat per key: m_match (1 when the key encrypts the plaintext register to
//   the ciphertext register) and m_key_echo (the key that was tested).
//   Config port cfg_we/cfg_index/cfg_wdata writes plaintext (index 0) and
//   ciphertext (index 1); write only while the pipe is drained.
// Pipeline: load stage with PC-1 and IP, one register stage per DES round,
//   then final permutation and compare into the output register.
// Throughput: one key per cycle when not stalled; the round stages are
//   independent, so a new key enters every cycle while older keys are still in flight.
// Reset: synchronous active-low aresetn clears all stage valid bits and
//   both config registers.
// Stall: when m_valid is high and m_ready low the whole pipe freezes
//   (s_ready low); nothing is dropped or duplicated, and it resumes the
//   cycle m_ready rises.
`timescale 1ns / 1ps
module des_known_plaintext_key_check (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [55:0] s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_match,
    output logic [55:0] m_key_echo
);
`include "des_known_plaintext_key_check_assert.svh"

    localparam int NR = deskc_pkg::NumRounds;
    localparam logic CFG_PLAINTEXT  = 1'b0;
    localparam logic CFG_CIPHERTEXT = 1'b1;

    logic [63:0] plaintext_reg;
    logic [63:0] ciphertext_reg;

    // stage 0 = load, stages 1..NR = rounds
    logic        valid_reg [NR+1];
    logic [55:0] key_reg   [NR+1];
    logic [55:0] cd_reg    [NR+1];
    logic [31:0] l_reg     [NR+1];
    logic [31:0] r_reg     [NR+1];

    logic        out_valid_reg;
    logic        match_reg;
    logic [55:0] echo_reg;

    logic        advance;
    logic [63:0] ip_block;
    logic [63:0] ct_next;

    // whole pipe moves unless the output beat is stuck
    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = advance;
    assign ip_block = deskc_pkg::ip_perm(plaintext_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plaintext_reg  <= '0;
            ciphertext_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PLAINTEXT:  plaintext_reg  <= cfg_wdata;
                CFG_CIPHERTEXT: ciphertext_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // load stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (advance) begin
            valid_reg[0] <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            key_reg[0] <= s_key;
            cd_reg[0]  <= deskc_pkg::pc1_perm(s_key);
            l_reg[0]   <= ip_block[63:32];
            r_reg[0]   <= ip_block[31:0];
        end
    end

    // one DES round per stage, key schedule travels alongside
    for (genvar g = 1; g <= NR; g++) begin : g_round
        localparam logic TwoShift = (deskc_pkg::ROT_TAB[g-1] == 8'd2);
        logic [27:0] c_next;
        logic [27:0] d_next;
        logic [47:0] subkey;

        assign c_next = deskc_pkg::rot28(cd_reg[g-1][55:28], TwoShift);
        assign d_next = deskc_pkg::rot28(cd_reg[g-1][27:0], TwoShift);
        assign subkey = deskc_pkg::pc2_perm({c_next, d_next});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[g] <= 1'b0;
            end else if (advance) begin
                valid_reg[g] <= valid_reg[g-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (advance) begin
                key_reg[g] <= key_reg[g-1];
                cd_reg[g]  <= {c_next, d_next};
                l_reg[g]   <= r_reg[g-1];
                r_reg[g]   <= l_reg[g-1] ^ deskc_pkg::feistel(r_reg[g-1], subkey);
            end
        end
    end

    // final swap, FP and compare
    assign ct_next = deskc_pkg::fp_perm({r_reg[NR], l_reg[NR]});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= valid_reg[NR];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            match_reg <= (ct_next == ciphertext_reg);
            echo_reg  <= key_reg[NR];
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_match    = match_reg;
    assign m_key_echo = echo_reg;

    `KC_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)
    `KC_ASSERT_NXT(a_stall_holds, aclk, aresetn, m_valid && !m_ready,
                   m_valid && $stable(m_key_echo) && $stable(m_match))
    `KC_ASSERT_NXT(a_last_to_out, aclk, aresetn, valid_reg[NR] && advance,
                   m_valid && (m_key_echo == $past(key_reg[NR])))
    `KC_ASSERT_NXT(a_load_to_round, aclk, aresetn, valid_reg[0] && advance,
                   valid_reg[1] && (key_reg[1] == $past(key_reg[0])))

endmodule
